@@ rtl/core/ffpa_pkg.sv @@
// ============================================================================
// ffpa_pkg : shared definitions for the first-fit partition allocator
// Command and status codes, word layouts and parameter defaults.
// ============================================================================
`default_nettype none

package ffpa_pkg;

    // parameter defaults
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_SIZE_BITS    = 16;

    // field widths of the stream words
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam int FRAG_W   = 16;
    localparam int INUSE_W  = 5;

    localparam int IN_DATA_W  = 24;   // 19 bits used
    localparam int OUT_DATA_W = 48;   // 44 bits used

    // input word layout
    localparam int IN_CMD_LSB  = 0;
    localparam int IN_SIZE_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_FLAG_LSB = IN_SIZE_LSB + SIZE_W;

    // output word layout
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_INDEX_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_FRAG_LSB   = OUT_INDEX_LSB + INDEX_W;
    localparam int OUT_TOTAL_LSB  = OUT_FRAG_LSB + FRAG_W;
    localparam int OUT_INUSE_LSB  = OUT_TOTAL_LSB + FRAG_W;
    localparam int OUT_USED_W     = OUT_INUSE_LSB + INUSE_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STS_CLEARED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_LOADED    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ALLOCATED = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NO_FIT    = 3'd4;

    // configuration
    localparam int                 APB_ADDR_W     = 3;
    localparam logic [SIZE_W-1:0]  MEM_SIZE_RESET = 16'hFFFF;
    localparam logic               REG_MEM_SIZE   = 1'b0;   // word index of memory_size

endpackage : ffpa_pkg

`default_nettype wire

@@ rtl/core/ffpa_sub_unit.sv @@
// ============================================================================
// ffpa_sub_unit : shared subtract / compare unit
// Computes a - b and flags a >= b; time-shared by the load and scan steps.
// ============================================================================
`default_nettype none

module ffpa_sub_unit #(
    parameter int OP_W = 17
) (
    input  wire logic [OP_W-1:0] i_a,
    input  wire logic [OP_W-1:0] i_b,
    output logic      [OP_W-1:0] o_diff,
    output logic                 o_geq
);

    logic [OP_W:0] w_full;

    // one extra bit catches the borrow
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[OP_W-1:0];
    assign o_geq  = ~w_full[OP_W];

endmodule : ffpa_sub_unit

`default_nettype wire

@@ rtl/core/first_fit_partition_allocator.sv @@
// ============================================================================
// first_fit_partition_allocator : fixed-partition first-fit allocator
// Segment table built by load commands; allocate picks the first free fit.
// ============================================================================
// Usage
//   Slave stream (i_s_*) carries one command word: clear, load or allocate.
//   Master stream (o_m_*) returns exactly one result word per command.
//   APB port holds memory_size at byte address 0 (write only while idle).
//   One command is in flight at a time; o_s_tready is high only in idle.
//   Steps from accept to result valid: clear, rejected load and unused
//   codes go straight to the done state; load passes the room calc, fit
//   check and done states; allocate scans from segment 0 up to the first
//   free fit or the last segment in the table, then goes to done.
//   The allocate scan reads the size table once per cycle through one
//   registered memory port and one shared subtract/compare unit; no new
//   command is taken until the scan has ended.
//   The result sits in an output register: a new command is taken while a
//   result still waits, and a finished command holds in its done state
//   while the receiver stalls with the output register full.
//   Reset empties the table, clears totals and sets memory_size to all ones.
// ============================================================================
`default_nettype none

module first_fit_partition_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int SIZE_BITS    = DEF_SIZE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [1:0] command, [17:2] size_value, [18] free_flag
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [2:0] status, [6:3] segment_index, [22:7] fragmentation,
    // [38:23] total_fragmentation, [43:39] segments_in_use
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // configuration
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]           i_pwdata,
    output logic [31:0]                o_prdata,
    output logic                       o_pready
);

    // sizes are taken at most 16 bits wide
    localparam int VAL_W = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
    localparam int OP_W  = VAL_W + 1;
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOM = 3'd1;
    localparam logic [2:0] S_FIT  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // ---------------- state ----------------
    logic [2:0]              r_state;
    logic [VAL_W-1:0]        r_mem_size;
    logic [SIZE_BITS-1:0]    r_sizes [MAX_SEGMENTS];   // no reset: read only below count
    logic [MAX_SEGMENTS-1:0] r_free;
    logic [CNT_W-1:0]        r_count;
    logic [OP_W-1:0]         r_sum;
    logic                    r_closed;
    logic [VAL_W-1:0]        r_total;

    // current command
    logic [VAL_W-1:0]        r_val;
    logic                    r_flag;
    logic [VAL_W-1:0]        r_room;
    logic                    r_over;   // loaded sum already past memory_size

    // scan pipeline
    logic [CNT_W-1:0]        r_ptr;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_live;
    logic [SIZE_BITS-1:0]    r_rd_data;

    // pending result
    logic [STATUS_W-1:0]     r_res_status;
    logic [IDX_W-1:0]        r_res_idx;
    logic [VAL_W-1:0]        r_res_frag;

    // output register
    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_data;

    // ---------------- input decode ----------------
    logic             w_s_fire;
    logic [CMD_W-1:0] w_cmd;
    logic [VAL_W-1:0] w_val;
    logic             w_flag;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_fire   = i_s_tvalid & o_s_tready;
    assign w_cmd      = i_s_tdata[IN_CMD_LSB +: CMD_W];
    assign w_val      = i_s_tdata[IN_SIZE_LSB +: VAL_W];
    assign w_flag     = i_s_tdata[IN_FLAG_LSB];

    // ---------------- shared subtract / compare ----------------
    logic [OP_W-1:0] w_op_a;
    logic [OP_W-1:0] w_op_b;
    logic [OP_W-1:0] w_diff;
    logic            w_geq;

    always_comb begin
        case (r_state)
            S_ROOM: begin
                w_op_a = {1'b0, r_mem_size};    // room = memory_size - loaded sum
                w_op_b = r_sum;
            end
            S_FIT: begin
                w_op_a = {1'b0, r_room};        // does the segment fit the room
                w_op_b = {1'b0, r_val};
            end
            default: begin
                w_op_a = {1'b0, r_rd_data[VAL_W-1:0]};  // segment size vs request
                w_op_b = {1'b0, r_val};
            end
        endcase
    end

    ffpa_sub_unit #(
        .OP_W (OP_W)
    ) u_sub (
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_diff (w_diff),
        .o_geq  (w_geq)
    );

    // ---------------- derived values ----------------
    logic             w_full;
    logic [VAL_W-1:0] w_stored;
    logic [OP_W-1:0]  n_sum;
    logic [OP_W-1:0]  w_total_raw;
    logic [VAL_W-1:0] n_total;
    logic             w_hit;
    logic             w_last;
    logic             w_out_free;

    assign w_full      = (r_count >= CNT_W'(MAX_SEGMENTS));
    assign w_stored    = w_geq ? r_val : r_room;
    assign n_sum       = r_sum + {1'b0, w_stored};
    assign w_total_raw = {1'b0, r_total} + {1'b0, w_diff[VAL_W-1:0]};
    assign n_total     = w_total_raw[VAL_W] ? {VAL_W{1'b1}} : w_total_raw[VAL_W-1:0];
    assign w_hit       = r_rd_live & r_free[r_rd_idx] & w_geq;
    assign w_last      = (CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count;
    assign w_out_free  = ~r_m_valid | i_m_tready;

    // ---------------- size table ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIT) begin
            r_sizes[r_count[IDX_W-1:0]] <= SIZE_BITS'(w_stored);
        end
        r_rd_data <= r_sizes[r_ptr[IDX_W-1:0]];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_closed  <= 1'b0;
            r_total   <= '0;
            r_rd_live <= 1'b0;
            r_ptr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_idx <= r_ptr[IDX_W-1:0];

            if (r_state == S_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_val        <= w_val;
                        r_flag       <= w_flag;
                        r_res_idx    <= '0;
                        r_res_frag   <= '0;
                        case (w_cmd)
                            CMD_CLEAR: begin
                                r_free       <= '0;
                                r_count      <= '0;
                                r_sum        <= '0;
                                r_closed     <= 1'b0;
                                r_total      <= '0;
                                r_res_status <= STS_CLEARED;
                                r_state      <= S_DONE;
                            end
                            CMD_LOAD: begin
                                if (r_closed || w_full) begin
                                    r_res_status <= STS_REJECTED;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_state <= S_ROOM;
                                end
                            end
                            CMD_ALLOC: begin
                                // empty table misses at once
                                r_res_status <= STS_NO_FIT;
                                if (r_count != '0) begin
                                    r_ptr     <= '0;
                                    r_rd_live <= 1'b0;
                                    r_state   <= S_SCAN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_res_status <= STS_NO_FIT;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end

                S_ROOM: begin
                    // sum beyond a shrunken memory_size leaves no room
                    r_room  <= w_geq ? w_diff[VAL_W-1:0] : '0;
                    r_over  <= ~w_geq;
                    r_state <= S_FIT;
                end

                S_FIT: begin
                    r_free[r_count[IDX_W-1:0]] <= r_flag;
                    r_res_idx    <= r_count[IDX_W-1:0];
                    r_res_status <= STS_LOADED;
                    r_count      <= r_count + CNT_W'(1);
                    r_sum        <= n_sum;
                    if (!w_geq || r_over) begin
                        r_closed <= 1'b1;   // cut to the room, table closes
                    end
                    r_state <= S_DONE;
                end

                S_SCAN: begin
                    r_ptr <= r_ptr + CNT_W'(1);
                    if (w_hit) begin
                        r_free[r_rd_idx] <= 1'b0;
                        r_res_idx        <= r_rd_idx;
                        r_res_frag       <= w_diff[VAL_W-1:0];
                        r_res_status     <= STS_ALLOCATED;
                        r_total          <= n_total;
                        r_rd_live        <= 1'b0;
                        r_state          <= S_DONE;
                    end else if (r_rd_live && w_last) begin
                        r_rd_live <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_rd_live <= 1'b1;
                    end
                end

                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word, built from table state after the command
    logic [31:0] w_idx_ext;
    logic [31:0] w_cnt_ext;

    assign w_idx_ext = 32'(r_res_idx);
    assign w_cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_m_data <= {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                         w_cnt_ext[INUSE_W-1:0],
                         FRAG_W'(r_total),
                         FRAG_W'(r_res_frag),
                         w_idx_ext[INDEX_W-1:0],
                         r_res_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // ---------------- configuration ----------------
    logic w_reg_sel;

    assign o_pready  = 1'b1;
    assign w_reg_sel = (i_paddr[APB_ADDR_W-1] == REG_MEM_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= MEM_SIZE_RESET[VAL_W-1:0];
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_reg_sel) begin
            r_mem_size <= i_pwdata[VAL_W-1:0];
        end
    end

    assign o_prdata = w_reg_sel ? 32'(r_mem_size) : '0;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_rd_live) |-> (CNT_W'(r_rd_idx) < r_count))
        else $error("scan examined an entry outside the table");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> !o_s_tready)
        else $error("second command taken while one is in flight");

    a_hit_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_hit) |=> (r_res_status == STS_ALLOCATED))
        else $error("allocation hit not reported");

endmodule : first_fit_partition_allocator

`default_nettype wire
